// File: hdl/dcs_pkg.sv
`default_nettype none
package dcs_pkg;

  // block geometry
  localparam int BLK_N  = 8;
  localparam int IDX_W  = $clog2(BLK_N);
  localparam int NPIX   = BLK_N * BLK_N;
  localparam int PIX_AW = $clog2(NPIX);
  localparam int PIX_W  = 8;

  // datapath widths
  localparam int OP_W   = 24;   // cell operand: pixel or row-pass value (Q12)
  localparam int CF_W   = 16;   // cosine entry, Q15
  localparam int ACC_W  = 44;   // running sum through the chain
  localparam int WIDE_W = 66;   // rounding and saturation work width
  localparam int RQ_W   = 33;   // column result rounded to Q16
  localparam int VAL_W  = 16;
  localparam int CFG_W  = 64;
  localparam int SCL_W  = 32;

  typedef enum logic [1:0] {
    CFG_COEF_SELECT,
    CFG_OUTPUT_MODE,
    CFG_QUANT_RECIP_SCALE
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_COLLECT,
    ST_ROW_LOAD,
    ST_ROW_STREAM,
    ST_ROW_DRAIN,
    ST_COL_LOAD,
    ST_COL_STREAM,
    ST_COL_DRAIN,
    ST_EM_SEL,
    ST_EM_RND,
    ST_EM_MUL,
    ST_EM_OUT
  } state_t;

  // token that walks down the chain of cells
  typedef struct packed {
    logic                    vld;
    logic [IDX_W-1:0]        sel;
    logic signed [ACC_W-1:0] sum;
  } tok_t;

  // 16384 * cos(a * pi / 16), a = 0..8
  function automatic logic signed [CF_W-1:0] cos_mag(input logic [3:0] a);
    logic signed [CF_W-1:0] r;
    case (a)
      4'd0:    r = 16'sd16384;
      4'd1:    r = 16'sd16069;
      4'd2:    r = 16'sd15137;
      4'd3:    r = 16'sd13623;
      4'd4:    r = 16'sd11585;
      4'd5:    r = 16'sd9102;
      4'd6:    r = 16'sd6270;
      4'd7:    r = 16'sd3196;
      default: r = 16'sd0;
    endcase
    return r;
  endfunction

  // orthonormal dct-ii matrix entry c[i][k] in Q15
  function automatic logic signed [CF_W-1:0] dct_coef(input logic [IDX_W-1:0] i,
                                                      input logic [IDX_W-1:0] k);
    logic [4:0]             a;
    logic [7:0]             p;
    logic signed [CF_W-1:0] r;
    p = 8'((2 * k + 1) * i);
    a = p[4:0];
    if (i == '0)
      r = 16'sd11585;
    else if (a <= 5'd8)
      r = cos_mag(a[3:0]);
    else if (a <= 5'd16)
      r = -cos_mag(4'(5'd16 - a));
    else if (a <= 5'd24)
      r = -cos_mag(4'(a - 5'd16));
    else
      r = cos_mag(4'(6'd32 - 6'(a)));
    return r;
  endfunction

  // shift right with rounding to nearest, ties away from zero (s >= 1)
  function automatic logic signed [WIDE_W-1:0] rnd_sh(input logic signed [WIDE_W-1:0] v,
                                                      input int unsigned s);
    logic signed [WIDE_W-1:0] h;
    logic signed [WIDE_W-1:0] n;
    h = WIDE_W'(1) <<< (s - 1);
    n = v[WIDE_W-1] ? WIDE_W'(1) : WIDE_W'(0);
    return (v + h - n) >>> s;
  endfunction

  function automatic logic signed [WIDE_W-1:0] sat_w(input logic signed [WIDE_W-1:0] v,
                                                     input logic signed [WIDE_W-1:0] lo,
                                                     input logic signed [WIDE_W-1:0] hi);
    logic signed [WIDE_W-1:0] r;
    if (v < lo)
      r = lo;
    else if (v > hi)
      r = hi;
    else
      r = v;
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hdl/dcs_ram.sv
`default_nettype none
module dcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: hdl/dcs_cell.sv
`default_nettype none
module dcs_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               shift_en,
  input  wire logic [dcs_pkg::IDX_W-1:0]          cell_k,
  input  wire logic signed [dcs_pkg::OP_W-1:0]    op_in,
  output logic signed [dcs_pkg::OP_W-1:0]         op_out,
  input  wire dcs_pkg::tok_t                      tok_in,
  output dcs_pkg::tok_t                           tok_out
);
  import dcs_pkg::*;

  logic signed [CF_W-1:0]      coef;
  logic signed [OP_W+CF_W-1:0] prod;

  assign coef = dct_coef(tok_in.sel, cell_k);
  assign prod = op_out * coef;

  // operand shifts in from the left neighbor during a load
  always_ff @(posedge clk) begin
    if (shift_en) begin
      op_out <= op_in;
    end
  end

  // add this cell's product to the passing token
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
    tok_out.sel <= tok_in.sel;
    tok_out.sum <= tok_in.sum + ACC_W'(prod);
  end

endmodule
`default_nettype wire

// File: hdl/block_dct_coef_select.sv
`default_nettype none
// channel   dir  signals                       content
// s_axis    in   s_tvalid s_tready s_tdata     tdata[7:0] pixel
// m_axis    out  m_tvalid m_tready m_tdata     tdata[15:0] coef_value, [21:16] coef_index
//                m_tlast                       last_coef
// cfg       in   cfg_we cfg_index cfg_data     0 coef_select, 1 output_mode, 2 quant scale
//
// pixels are taken one per cycle while collecting; after the 64th, the single
// eight-cell chain runs the eight row vectors, then per output row a column
// vector (load, stream, drain each) and the emit step: select, round, multiply
// and output for a selected coefficient, select only for others; then collect.
// rst is synchronous; output stalls hold the emit step only.
module block_dct_coef_select (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [7:0]                    s_tdata,   // [7:0] pixel
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [23:0]                        m_tdata,   // [15:0] coef_value, [21:16] coef_index
  output logic                               m_tlast,   // last_coef
  input  wire logic                          cfg_we,
  input  wire logic [1:0]                    cfg_index,
  input  wire logic [dcs_pkg::CFG_W-1:0]     cfg_data
);
  import dcs_pkg::*;

  // configuration
  logic [CFG_W-1:0] coef_select;
  logic             output_mode;
  logic [SCL_W-1:0] quant_recip_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_select       <= '1;
      output_mode       <= 1'b0;
      quant_recip_scale <= SCL_W'(65536);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_COEF_SELECT:       coef_select       <= cfg_data;
        CFG_OUTPUT_MODE:       output_mode       <= cfg_data[0];
        CFG_QUANT_RECIP_SCALE: quant_recip_scale <= cfg_data[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic [PIX_AW-1:0] pix_cnt;
  logic [3:0]        step;
  logic [IDX_W-1:0]  vec;
  logic [IDX_W-1:0]  drain_cnt;
  logic [IDX_W-1:0]  emj;

  logic              pix_we;
  logic [PIX_AW-1:0] pix_raddr;
  logic [PIX_W-1:0]  pix_rdata;
  logic              row_we;
  logic [PIX_AW-1:0] row_raddr;
  logic [OP_W-1:0]   row_wdata;
  logic [OP_W-1:0]   row_rdata;
  logic              shift_en;
  logic signed [OP_W-1:0] feed;
  logic [IDX_W-1:0]  kload;
  logic              sel_bit;
  logic              out_free;
  logic              em_adv;
  logic              drain_done;

  tok_t tok [BLK_N+1];
  logic signed [OP_W-1:0] ops [BLK_N+1];

  logic signed [ACC_W-1:0]  col_buf [BLK_N];
  logic signed [VAL_W-1:0]  val0;
  logic signed [RQ_W-1:0]   rq;
  logic signed [WIDE_W-1:0] prod;

  assign kload      = IDX_W'(BLK_N - 1) - step[IDX_W-1:0];
  assign sel_bit    = coef_select[{vec, emj}];
  assign out_free   = !m_tvalid || m_tready;
  assign drain_done = tok[BLK_N].vld && (drain_cnt == IDX_W'(BLK_N - 1));
  assign em_adv     = (state == ST_EM_SEL && !sel_bit) || (state == ST_EM_OUT && out_free);

  // memories
  dcs_ram #(.WIDTH(PIX_W), .DEPTH(NPIX)) u_pix_ram (
    .clk(clk), .we(pix_we), .waddr(pix_cnt), .wdata(s_tdata),
    .raddr(pix_raddr), .rdata(pix_rdata)
  );

  dcs_ram #(.WIDTH(OP_W), .DEPTH(NPIX)) u_row_ram (
    .clk(clk), .we(row_we), .waddr({tok[BLK_N].sel, vec}), .wdata(row_wdata),
    .raddr(row_raddr), .rdata(row_rdata)
  );

  // chain of mac cells
  assign ops[0] = feed;
  for (genvar g = 0; g < BLK_N; g++) begin : g_cell
    dcs_cell u_cell (
      .clk(clk), .rst(rst), .shift_en(shift_en), .cell_k(IDX_W'(g)),
      .op_in(ops[g]), .op_out(ops[g+1]), .tok_in(tok[g]), .tok_out(tok[g+1])
    );
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_COLLECT:
        if (s_tvalid && pix_cnt == PIX_AW'(NPIX - 1)) state_next = ST_ROW_LOAD;
      ST_ROW_LOAD:
        if (step == 4'(BLK_N)) state_next = ST_ROW_STREAM;
      ST_ROW_STREAM:
        if (step == 4'(BLK_N - 1)) state_next = ST_ROW_DRAIN;
      ST_ROW_DRAIN:
        if (drain_done)
          state_next = (vec == IDX_W'(BLK_N - 1)) ? ST_COL_LOAD : ST_ROW_LOAD;
      ST_COL_LOAD:
        if (step == 4'(BLK_N)) state_next = ST_COL_STREAM;
      ST_COL_STREAM:
        if (step == 4'(BLK_N - 1)) state_next = ST_COL_DRAIN;
      ST_COL_DRAIN:
        if (drain_done) state_next = ST_EM_SEL;
      ST_EM_SEL:
        if (sel_bit) begin
          state_next = ST_EM_RND;
        end else if (emj == IDX_W'(BLK_N - 1)) begin
          state_next = (vec == IDX_W'(BLK_N - 1)) ? ST_COLLECT : ST_COL_LOAD;
        end
      ST_EM_RND:
        state_next = ST_EM_MUL;
      ST_EM_MUL:
        state_next = ST_EM_OUT;
      ST_EM_OUT:
        if (out_free) begin
          if (emj != IDX_W'(BLK_N - 1))
            state_next = ST_EM_SEL;
          else
            state_next = (vec == IDX_W'(BLK_N - 1)) ? ST_COLLECT : ST_COL_LOAD;
        end
      default:
        state_next = ST_COLLECT;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready  = 1'b0;
    pix_we    = 1'b0;
    row_we    = 1'b0;
    shift_en  = 1'b0;
    pix_raddr = {kload, vec};
    row_raddr = {vec, kload};
    feed      = $signed(row_rdata);
    tok[0]    = '0;
    row_wdata = OP_W'(sat_w(rnd_sh(WIDE_W'(tok[BLK_N].sum), 3),
                            -(WIDE_W'(1) <<< (OP_W - 1)),
                            (WIDE_W'(1) <<< (OP_W - 1)) - WIDE_W'(1)));
    case (state)
      ST_COLLECT: begin
        s_tready = 1'b1;
        pix_we   = s_tvalid;
      end
      ST_ROW_LOAD: begin
        shift_en = (step != 4'd0);
        feed     = $signed(OP_W'(pix_rdata));
      end
      ST_COL_LOAD: begin
        shift_en = (step != 4'd0);
      end
      ST_ROW_STREAM, ST_COL_STREAM: begin
        tok[0].vld = 1'b1;
        tok[0].sel = step[IDX_W-1:0];
      end
      default: ;
    endcase
    if (state == ST_ROW_STREAM || state == ST_ROW_DRAIN) begin
      row_we = tok[BLK_N].vld;
    end
  end

  // sequencer counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_COLLECT;
      pix_cnt   <= '0;
      step      <= '0;
      vec       <= '0;
      drain_cnt <= '0;
      emj       <= '0;
    end else begin
      state <= state_next;
      if (state == ST_COLLECT && s_tvalid) begin
        pix_cnt <= pix_cnt + PIX_AW'(1);
      end
      step <= (state_next != state) ? 4'd0 : step + 4'd1;
      if (state_next == ST_ROW_LOAD || state_next == ST_COL_LOAD) begin
        drain_cnt <= '0;
      end else if (tok[BLK_N].vld) begin
        drain_cnt <= drain_cnt + IDX_W'(1);
      end
      if (state == ST_ROW_DRAIN && drain_done) begin
        vec <= vec + IDX_W'(1);
      end else if (em_adv && emj == IDX_W'(BLK_N - 1)) begin
        vec <= vec + IDX_W'(1);
      end
      if (em_adv) begin
        emj <= emj + IDX_W'(1);
      end
    end
  end

  // column results of one row
  always_ff @(posedge clk) begin
    if ((state == ST_COL_STREAM || state == ST_COL_DRAIN) && tok[BLK_N].vld) begin
      col_buf[tok[BLK_N].sel] <= tok[BLK_N].sum;
    end
  end

  // output scaling pipeline
  always_ff @(posedge clk) begin
    if (state == ST_EM_RND) begin
      val0 <= VAL_W'(sat_w(rnd_sh(WIDE_W'(col_buf[emj]), 23),
                           -WIDE_W'(32768), WIDE_W'(32767)));
      rq   <= RQ_W'(rnd_sh(WIDE_W'(col_buf[emj]), 11));
    end
    if (state == ST_EM_MUL) begin
      prod <= rq * $signed({1'b0, quant_recip_scale});
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EM_OUT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (state == ST_EM_OUT && out_free) begin
      m_tdata[15:0]  <= output_mode ?
                        VAL_W'(sat_w(rnd_sh(prod, 32), -WIDE_W'(128), WIDE_W'(127))) :
                        val0;
      m_tdata[21:16] <= {vec, emj};
      m_tdata[23:22] <= 2'b00;
      m_tlast        <= ((coef_select >> {vec, emj}) >> 1) == '0;
    end
  end

endmodule
`default_nettype wire

// File: verif/block_dct_coef_select_test.sv
`timescale 1ns / 1ps
module block_dct_coef_select_test;
  import dcs_pkg::*;

  localparam longint PI_Q30      = 64'sd3373259426;
  localparam longint ONE_Q30     = 64'sd1073741824;
  localparam int     FRAC        = 4;
  localparam int     SETTLE      = 800;
  localparam int     STALL_LIMIT = 20000;
  // the block has three registers, index 3 goes nowhere
  localparam logic [1:0] CFG_NO_REG = 2'd3;

  typedef struct packed {
    logic signed [15:0] value;
    logic [5:0]         idx;
    logic               last;
  } coef_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [23:0]          m_tdata;
  logic                 m_tlast;
  logic                 cfg_we = 1'b0;
  logic [1:0]           cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;

  // pixel stream and expected coefficients
  logic [7:0]           pixel_queue[$];
  coef_t                expected_coefs[$];

  // predictor state
  longint               cos_q15[64];
  logic [7:0]           pix_mem[64];
  longint               row_mem[64];
  int                   pix_pos = 0;
  logic [63:0]          sel_map = '1;
  logic                 quant_mode = 1'b0;
  logic [31:0]          recip_scale = 32'd65536;

  logic                 in_fire = 1'b0;
  int                   burst_left = 0;
  int                   gap_left = 0;
  int unsigned          rcv_cnt = 0;
  int                   mismatches = 0;
  int                   stall_cycles = 0;

  block_dct_coef_select dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // round to nearest, ties away from zero
  function automatic longint rnd_shift(longint v, int s);
    longint unsigned m;
    if (s == 0)
      return v;
    m = (v < 0) ? longint'(0) - v : v;
    m = (m + (64'd1 << (s - 1))) >> s;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v)
      b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // cos(r * pi / 16) in Q30 by taylor series, r in first quadrant
  function automatic longint cos_quadrant(longint r);
    longint x;
    longint term;
    longint acc;
    x = PI_Q30 * r / 16;
    term = ONE_Q30;
    acc = ONE_Q30;
    for (longint k = 1; k <= 12; k++) begin
      term = -(term * x / ONE_Q30);
      term = term * x / ONE_Q30;
      term = term / ((2 * k - 1) * (2 * k));
      acc += term;
    end
    return acc;
  endfunction

  function automatic void build_cos_table();
    longint a0;
    longint a1;
    longint a;
    longint c;
    a0 = int_sqrt((64'd1 << 60) / 8);
    a1 = int_sqrt((64'd1 << 61) / 8);
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        a = ((2 * j + 1) * i) % 32;
        if (a <= 8)
          c = cos_quadrant(a);
        else if (a <= 16)
          c = -cos_quadrant(16 - a);
        else if (a <= 24)
          c = -cos_quadrant(a - 16);
        else
          c = cos_quadrant(32 - a);
        c = c * ((i == 0) ? a0 : a1) / ONE_Q30;
        cos_q15[i * 8 + j] = rnd_shift(c, 15);
      end
  endfunction

  // store a pixel; the 64th one yields the selected coefficients
  function automatic void take_pixel(logic [7:0] p);
    longint acc;
    longint v;
    int     last_idx;
    coef_t  c;
    pix_mem[pix_pos] = p;
    if (pix_pos != 63) begin
      pix_pos++;
      return;
    end
    pix_pos = 0;
    // row pass, Q12
    for (int i = 0; i < 8; i++)
      for (int j = 0; j < 8; j++) begin
        acc = 0;
        for (int k = 0; k < 8; k++)
          acc += cos_q15[i * 8 + k] * longint'(pix_mem[k * 8 + j]);
        row_mem[i * 8 + j] = clamp(rnd_shift(acc, 3), -8388608, 8388607);
      end
    last_idx = -1;
    for (int i = 0; i < 64; i++)
      if (sel_map[i])
        last_idx = i;
    // column pass, Q27, then output format
    for (int idx = 0; idx < 64; idx++) begin
      if (!sel_map[idx])
        continue;
      acc = 0;
      for (int k = 0; k < 8; k++)
        acc += row_mem[(idx / 8) * 8 + k] * cos_q15[(idx % 8) * 8 + k];
      if (!quant_mode) begin
        v = clamp(rnd_shift(acc, 27 - FRAC), -32768, 32767);
      end else begin
        v = rnd_shift(acc, 11) * longint'(recip_scale);
        v = clamp(rnd_shift(v, 32), -128, 127);
      end
      c.value = v[15:0];
      c.idx = idx[5:0];
      c.last = (idx == last_idx);
      expected_coefs.insert(expected_coefs.size(), c);
    end
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_COEF_SELECT:       sel_map = val;
      CFG_OUTPUT_MODE:       quant_mode = val[0];
      CFG_QUANT_RECIP_SCALE: recip_scale = val[31:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random_block();
    for (int i = 0; i < 64; i++)
      pixel_queue.insert(pixel_queue.size(), 8'($urandom_range(0, 255)));
  endtask

  // wait until the block has taken everything and sent every coefficient
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || s_tvalid || expected_coefs.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // item sender: bursts with random gaps
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (pixel_queue.size() != 0) begin
        s_tdata <= pixel_queue.pop_front();
        s_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern: free windows, light stalls, heavy stalls
  always @(negedge clk) begin
    rcv_cnt++;
    case (rcv_cnt[8:6])
      3'd1, 3'd4: m_tready <= ($urandom_range(0, 3) != 0);
      3'd6:       m_tready <= ($urandom_range(0, 7) == 0);
      default:    m_tready <= 1'b1;
    endcase
  end

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      take_pixel(s_tdata);
  end

  // output check against the oldest expected coefficient
  always @(posedge clk) begin
    coef_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_coefs.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected coefficient: value %0d index %0d last %0b",
                   $signed(m_tdata[15:0]), m_tdata[21:16], m_tlast);
        mismatches++;
      end else begin
        e = expected_coefs.pop_front();
        if (m_tdata[15:0] !== e.value || m_tdata[21:16] !== e.idx || m_tlast !== e.last) begin
          if (mismatches < 10)
            $display("mismatch: expected value %0d index %0d last %0b, got %0d %0d %0b",
                     e.value, e.idx, e.last, $signed(m_tdata[15:0]), m_tdata[21:16],
                     m_tlast);
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no item moving
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    build_cos_table();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: flat white block
    for (int i = 0; i < 64; i++)
      pixel_queue.insert(pixel_queue.size(), 8'hff);
    wait_idle();

    // quantized at unit scale, checkerboard drives the high frequencies
    write_reg(CFG_OUTPUT_MODE, 64'd1);
    for (int i = 0; i < 64; i++)
      pixel_queue.insert(pixel_queue.size(),
                         (((i / 8) + (i % 8)) % 2 == 1) ? 8'hff : 8'h00);
    wait_idle();

    // largest scale, random selection
    write_reg(CFG_QUANT_RECIP_SCALE, 64'hffff_ffff);
    write_reg(CFG_COEF_SELECT, {$urandom, $urandom});
    queue_random_block();
    wait_idle();

    // zero scale, only the top index
    write_reg(CFG_QUANT_RECIP_SCALE, 64'd0);
    write_reg(CFG_COEF_SELECT, 64'h8000_0000_0000_0000);
    queue_random_block();
    wait_idle();

    // empty selection gives no coefficients; a write to a missing register is dropped
    write_reg(CFG_OUTPUT_MODE, 64'd0);
    write_reg(CFG_COEF_SELECT, 64'd0);
    write_reg(CFG_NO_REG, 64'hffff_ffff_ffff_ffff);
    queue_random_block();
    wait_idle();

    // random settings for the remaining block
    for (int b = 0; b < 1; b++) begin
      write_reg(CFG_COEF_SELECT, ($urandom_range(0, 1) == 0) ? 64'hffff_ffff_ffff_ffff
                                                              : {$urandom, $urandom});
      write_reg(CFG_OUTPUT_MODE, 64'($urandom_range(0, 1)));
      write_reg(CFG_QUANT_RECIP_SCALE, 64'($urandom_range(4096, 1 << 20)));
      queue_random_block();
      wait_idle();
    end

    if (mismatches == 0 && expected_coefs.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
